// ----- hw/rtl/bwlp3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the three-axis low-pass biquad.
// No dependencies; every other file of the block imports this package.
package bwlp3_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int AXES      = 3;
    localparam int COEF_W    = 32;
    localparam int NUM_COEFS = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    typedef struct packed {
        logic    commit;
        logic    prime;
    } t_axis_ctrl;

    typedef struct packed {
        logic    restart;
        t_sample sample_x;
        t_sample sample_y;
        t_sample sample_z;
    } t_in_beat;

    typedef struct packed {
        t_sample filtered_x;
        t_sample filtered_y;
        t_sample filtered_z;
    } t_out_beat;

endpackage

// ----- hw/rtl/butterworth_lowpass_3axis.sv -----
`timescale 1ns / 1ps
// Top level of the three-axis second-order low-pass filter.
// Depends on bwlp3_pkg, bwlp3_coef_regs and bwlp3_axis.
//
// Usage:
// Each input beat carries one sample per axis and a restart flag; each
// beat yields exactly one output beat with the three filtered samples.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The five shared coefficients are to be written through
// the plain write port while the filter is idle; the block does not
// enforce this. A write to one of the five indexes unprimes the filter,
// so the next beat primes the filter and passes its samples through.
// A beat is captured in the input register, filtered and loaded into
// the output register when the output advances. One beat per cycle is
// sustained while the receiver does not stall; the clock is set by the
// combinational path of five parallel 32x24 products and their sum.
// While the receiver stalls, the output beat holds; the input register
// takes one more beat only if it is empty, and the input channel then
// stalls as well.
// Reset clears the coefficients to zero and marks the filter unprimed.
module butterworth_lowpass_3axis #(
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bwlp3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bwlp3_pkg::COEF_W-1:0]     i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bwlp3_pkg::t_in_beat              i_in_beat,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bwlp3_pkg::t_out_beat             o_out_beat
);
    import bwlp3_pkg::*;

    t_coefs     coefs;
    logic       cfg_clear;
    logic       r_in_valid;
    t_in_beat   r_in_beat;
    logic       r_out_valid;
    t_out_beat  r_out_beat;
    logic       r_primed;
    logic       advance;
    logic       commit;
    logic       take;
    t_axis_ctrl ctrl;
    t_sample    samples [AXES];
    t_sample    results [AXES];

    bwlp3_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coefs     (coefs),
        .o_clear     (cfg_clear)
    );

    assign advance = !r_out_valid || !i_out_stall;
    assign commit  = r_in_valid && advance;
    assign take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !advance;

    assign ctrl.commit = commit;
    assign ctrl.prime  = r_in_beat.restart || !r_primed;

    assign samples[0] = r_in_beat.sample_x;
    assign samples[1] = r_in_beat.sample_y;
    assign samples[2] = r_in_beat.sample_z;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        bwlp3_axis #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_axis (
            .i_clk    (i_clk),
            .i_ctrl   (ctrl),
            .i_coefs  (coefs),
            .i_sample (samples[g]),
            .o_result (results[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (commit) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (cfg_clear) begin
                r_primed <= 1'b0;
            end else if (commit) begin
                r_primed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_beat <= i_in_beat;
        end
        if (commit) begin
            r_out_beat.filtered_x <= results[0];
            r_out_beat.filtered_y <= results[1];
            r_out_beat.filtered_z <= results[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_cfg_unprimes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_clear |=> !r_primed)
        else $error("coefficient write left the filter primed");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed beat did not reach the output register");

    a_restart_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_in_beat.restart) |=>
            (o_out_beat.filtered_x == $past(r_in_beat.sample_x)))
        else $error("restart beat was not passed through");

endmodule

// ----- hw/rtl/bwlp3_coef_regs.sv -----
`timescale 1ns / 1ps
// Coefficient register file shared by all axes.
// Depends on bwlp3_pkg.
module bwlp3_coef_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bwlp3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bwlp3_pkg::COEF_W-1:0]     i_cfg_wdata,
    output bwlp3_pkg::t_coefs                o_coefs,
    output logic                             o_clear
);
    import bwlp3_pkg::*;

    t_coefs r_coefs;
    t_coefs n_coefs;
    logic   hit;

    always_comb begin
        n_coefs = r_coefs;
        hit     = 1'b0;
        if (i_cfg_wr_en) begin
            case (t_coef_idx'(i_cfg_index))
                COEF_B0: begin n_coefs.b0 = t_coef'(i_cfg_wdata); hit = 1'b1; end
                COEF_B1: begin n_coefs.b1 = t_coef'(i_cfg_wdata); hit = 1'b1; end
                COEF_B2: begin n_coefs.b2 = t_coef'(i_cfg_wdata); hit = 1'b1; end
                COEF_A1: begin n_coefs.a1 = t_coef'(i_cfg_wdata); hit = 1'b1; end
                COEF_A2: begin n_coefs.a2 = t_coef'(i_cfg_wdata); hit = 1'b1; end
                default: begin hit = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;
    assign o_clear = hit;

endmodule

// ----- hw/rtl/bwlp3_axis.sv -----
`timescale 1ns / 1ps
// One axis of the direct form I biquad: history registers and the
// five-product sum with rounding and saturation. Depends on bwlp3_pkg.
module bwlp3_axis #(
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                   i_clk,
    input  bwlp3_pkg::t_axis_ctrl  i_ctrl,
    input  bwlp3_pkg::t_coefs      i_coefs,
    input  bwlp3_pkg::t_sample     i_sample,
    output bwlp3_pkg::t_sample     o_result
);
    import bwlp3_pkg::*;

    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    t_sample r_x1;
    t_sample r_x2;
    t_sample r_y1;
    t_sample r_y2;

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    t_sample                  filt;
    t_sample                  result;

    always_comb begin
        p_b0    = i_coefs.b0 * i_sample;
        p_b1    = i_coefs.b1 * r_x1;
        p_b2    = i_coefs.b2 * r_x2;
        p_a1    = i_coefs.a1 * r_y1;
        p_a2    = i_coefs.a2 * r_y2;
        acc     = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
                - ACC_W'(p_a1) - ACC_W'(p_a2) + HALF;
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > SAT_HI) begin
            filt = SAT_HI[SAMPLE_W-1:0];
        end else if (shifted < SAT_LO) begin
            filt = SAT_LO[SAMPLE_W-1:0];
        end else begin
            filt = shifted[SAMPLE_W-1:0];
        end
        result = i_ctrl.prime ? i_sample : filt;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            if (i_ctrl.prime) begin
                r_x1 <= i_sample;
                r_x2 <= i_sample;
                r_y1 <= i_sample;
                r_y2 <= i_sample;
            end else begin
                r_x2 <= r_x1;
                r_x1 <= i_sample;
                r_y2 <= r_y1;
                r_y1 <= result;
            end
        end
    end

    assign o_result = result;

endmodule

// ----- bench/butterworth_lowpass_3axis_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for butterworth_lowpass_3axis: random input gaps and output stalls.
// Needs bwlp3_pkg and the filter RTL; a built-in biquad mirror predicts each output beat.
module butterworth_lowpass_3axis_tb;
    import bwlp3_pkg::*;

    localparam int FRAC_BITS = 28;
    localparam int SMAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SMIN = -SMAX - 1;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int WALK_STEP = 40000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 98;
    localparam int STUCK_LIMIT = 400;
    localparam int PRINT_CAP = 40;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = CFG_IDX_W'(NUM_COEFS);
    localparam t_coef HALF = 32'sh0800_0000;
    localparam t_coef CMAX = 32'sh7FFF_FFFF;
    localparam t_coef CMIN = 32'sh8000_0000;
    localparam t_coef BW_B0 = 32'sd18107314;
    localparam t_coef BW_B1 = 32'sd36214628;
    localparam t_coef BW_A1 = -32'sd306816367;
    localparam t_coef BW_A2 = 32'sd110810693;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_coef cfg_wdata = '0;
    logic in_vld = 1'b0;
    logic o_in_stall;
    t_in_beat in_beat = '0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    t_out_beat o_out_beat;

    logic in_taken = 1'b0;
    logic idling = 1'b0;
    int in_gap = 0;
    int out_gap = 0;
    int stuck_cycles = 0;
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int settings = 0;
    int walk_level [AXES];

    t_in_beat sample_queue [$];
    t_out_beat filtered_due [$];

    t_coef coef_reg [NUM_COEFS];
    longint x_hist1 [AXES];
    longint x_hist2 [AXES];
    longint y_hist1 [AXES];
    longint y_hist2 [AXES];
    logic filter_primed = 1'b0;

    butterworth_lowpass_3axis #(
        .COEF_FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_vld),
        .o_in_stall(o_in_stall),
        .i_in_beat(in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_beat(o_out_beat)
    );

    always #1 clk = ~clk;

    function automatic void clear_history();
        for (int a = 0; a < AXES; a++) begin
            x_hist1[a] = 0;
            x_hist2[a] = 0;
            y_hist1[a] = 0;
            y_hist2[a] = 0;
        end
        filter_primed = 1'b0;
    endfunction

    function automatic t_out_beat biquad_step(input t_in_beat b);
        longint x [AXES];
        longint y [AXES];
        longint acc;
        logic prime;
        t_out_beat r;
        x[0] = longint'(b.sample_x);
        x[1] = longint'(b.sample_y);
        x[2] = longint'(b.sample_z);
        prime = b.restart || !filter_primed;
        for (int a = 0; a < AXES; a++) begin
            if (prime) begin
                x_hist1[a] = x[a];
                x_hist2[a] = x[a];
                y_hist1[a] = x[a];
                y_hist2[a] = x[a];
                y[a] = x[a];
            end else begin
                acc = longint'(coef_reg[COEF_B0]) * x[a]
                    + longint'(coef_reg[COEF_B1]) * x_hist1[a]
                    + longint'(coef_reg[COEF_B2]) * x_hist2[a]
                    - longint'(coef_reg[COEF_A1]) * y_hist1[a]
                    - longint'(coef_reg[COEF_A2]) * y_hist2[a]
                    + (longint'(1) << (FRAC_BITS - 1));
                acc = acc >>> FRAC_BITS;
                if (acc > longint'(SMAX)) acc = longint'(SMAX);
                if (acc < longint'(SMIN)) acc = longint'(SMIN);
                x_hist2[a] = x_hist1[a];
                x_hist1[a] = x[a];
                y_hist2[a] = y_hist1[a];
                y_hist1[a] = acc;
                y[a] = acc;
            end
        end
        if (prime) filter_primed = 1'b1;
        r.filtered_x = t_sample'(y[0]);
        r.filtered_y = t_sample'(y[1]);
        r.filtered_z = t_sample'(y[2]);
        return r;
    endfunction

    function automatic t_sample pick_sample(input int style, input int axis);
        int step;
        if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 4))
                0: return t_sample'(SMAX);
                1: return t_sample'(SMIN);
                2: return '0;
                3: return '1;
                default: return t_sample'(1);
            endcase
        end
        case (style)
            0: return t_sample'($urandom);
            1: begin
                step = int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
                walk_level[axis] += step;
                if (walk_level[axis] > SMAX) walk_level[axis] = SMAX;
                if (walk_level[axis] < SMIN) walk_level[axis] = SMIN;
                return t_sample'(walk_level[axis]);
            end
            default: return t_sample'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input t_sample got, input t_sample want);
        if (got !== want)
            report_mismatch($sformatf("output beat %0d %s got %0d expected %0d",
                beats_out, name, got, want));
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input t_coef value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_coefs(input t_coef b0, input t_coef b1, input t_coef b2,
                              input t_coef a1, input t_coef a2);
        write_coef(COEF_B0, b0);
        write_coef(COEF_B1, b1);
        write_coef(COEF_B2, b2);
        write_coef(COEF_A1, a1);
        write_coef(COEF_A2, a2);
        settings++;
    endtask

    task automatic queue_sample(input logic restart, input int x, input int y, input int z);
        t_in_beat b;
        b.restart = restart;
        b.sample_x = t_sample'(x);
        b.sample_y = t_sample'(y);
        b.sample_z = t_sample'(z);
        sample_queue.push_back(b);
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (sample_queue.size() != 0 || in_vld || filtered_due.size() != 0);
    endtask

    always @(negedge clk) begin
        if (!in_vld || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_vld <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                if (idling && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 2);
                    in_vld <= 1'b0;
                end else begin
                    in_vld <= 1'b1;
                    in_beat <= sample_queue.pop_front();
                end
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_out_beat want;
        logic in_fire;
        logic out_fire;
        in_fire = rst_n && in_vld && !o_in_stall;
        out_fire = rst_n && (o_out_valid === 1'b1) && !out_stall;
        in_taken <= in_fire;
        if (rst_n && cfg_wr_en && cfg_index < NUM_COEFS) begin
            coef_reg[cfg_index] = cfg_wdata;
            clear_history();
        end
        if (in_fire) begin
            filtered_due.push_back(biquad_step(in_beat));
            beats_in++;
        end
        if (out_fire) begin
            if (filtered_due.size() == 0) begin
                report_mismatch("output beat with no input beat pending");
            end else begin
                want = filtered_due.pop_front();
                check_field("filtered_x", o_out_beat.filtered_x, want.filtered_x);
                check_field("filtered_y", o_out_beat.filtered_y, want.filtered_y);
                check_field("filtered_z", o_out_beat.filtered_z, want.filtered_z);
            end
            beats_out++;
        end
        if (in_fire || out_fire || cfg_wr_en || !rst_n) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no beat moved for %0d cycles", STUCK_LIMIT);
            $display("[butterworth_lowpass_3axis] ERROR");
            $finish;
        end
    end

    initial begin
        int style;
        int ca1;
        int ca2;
        int gain;
        for (int i = 0; i < NUM_COEFS; i++) coef_reg[i] = '0;
        for (int a = 0; a < AXES; a++) walk_level[a] = 0;
        clear_history();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        idling = 1'b1;

        // Coefficients are zero after reset, so only primed beats pass anything.
        queue_sample(1'b0, 0, 0, 0);
        queue_sample(1'b0, SMAX, SMIN, -1);
        queue_sample(1'b1, SMAX, SMIN, 1);
        queue_sample(1'b0, 5, -5, SMAX);
        wait_drained();

        // A gain of one half makes odd samples land exactly on a rounding tie.
        load_coefs(HALF, '0, '0, '0, '0);
        queue_sample(1'b0, 0, 0, 0);
        queue_sample(1'b0, 1, -1, -3);
        queue_sample(1'b0, 3, -2, SMAX);
        queue_sample(1'b0, SMIN, 2, -5);
        wait_drained();

        load_coefs(BW_B0, BW_B1, BW_B0, BW_A1, BW_A2);
        queue_sample(1'b0, SMIN, SMIN, SMIN);
        repeat (5) queue_sample(1'b0, SMAX, SMAX, 0);
        queue_sample(1'b1, SMAX, 0, SMIN);
        queue_sample(1'b0, 0, 0, 0);
        wait_drained();

        // Writes to unused indexes must leave both coefficients and history alone.
        for (int k = 0; k < (1 << CFG_IDX_W) - NUM_COEFS; k++)
            write_coef(CFG_IDX_W'(NUM_COEFS + k), t_coef'($urandom));
        queue_sample(1'b0, SMAX, SMIN, 1);
        queue_sample(1'b0, 0, SMAX, -1);
        wait_drained();

        load_coefs(CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_sample(1'b0, 1, -1, 0);
        queue_sample(1'b0, SMAX, SMIN, 7);
        queue_sample(1'b0, SMIN, SMAX, -7);
        wait_drained();
        load_coefs(CMIN, CMIN, CMIN, CMIN, CMIN);
        queue_sample(1'b0, 1, -1, 0);
        queue_sample(1'b0, SMAX, SMIN, 7);
        queue_sample(1'b0, SMIN, SMAX, -7);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            idling = (p < RAND_PHASES - 2) && (p % 3 != 2);
            case ($urandom_range(0, 4))
                0: begin
                    ca2 = $urandom_range(0, ONE / 10 * 9);
                    ca1 = -int'((longint'(ONE) + ca2) * $urandom_range(0, 95) / 100);
                    gain = ONE + ca1 + ca2;
                    load_coefs(t_coef'(gain / 4), t_coef'(gain / 2), t_coef'(gain / 4),
                        t_coef'(ca1), t_coef'(ca2));
                end
                1: load_coefs(t_coef'(int'($urandom_range(0, 2 * ONE)) - ONE),
                    t_coef'(int'($urandom_range(0, 2 * ONE)) - ONE),
                    t_coef'(int'($urandom_range(0, 2 * ONE)) - ONE),
                    t_coef'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE),
                    t_coef'(int'($urandom_range(0, 2 * ONE)) - ONE));
                2: load_coefs(t_coef'($urandom), t_coef'($urandom), t_coef'($urandom),
                    t_coef'($urandom), t_coef'($urandom));
                3: begin
                    write_coef(CFG_IDX_W'($urandom_range(0, (1 << CFG_IDX_W) - 1)),
                        t_coef'($urandom));
                    settings++;
                end
                default: ;
            endcase
            style = $urandom_range(0, 2);
            repeat (PHASE_ITEMS)
                queue_sample($urandom_range(0, 39) == 0, int'(pick_sample(style, 0)),
                    int'(pick_sample(style, 1)), int'(pick_sample(style, 2)));
            wait_drained();
        end

        repeat (6) @(posedge clk);
        $display("Checked %0d output beats from %0d input beats across %0d coefficient loads,",
            beats_out, beats_in, settings);
        $display("with restarts, rounding ties, saturation and writes to unused indexes.");
        if (mismatches == 0) begin
            $display("[butterworth_lowpass_3axis] OK");
        end else begin
            $display("[butterworth_lowpass_3axis] ERROR");
        end
        $finish;
    end

endmodule
